FILE: sv/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// Used by the front queue, the allocation engine and the top level.
`default_nettype none

package ffba_pkg;

    // Size of the free map. The request fields below have fixed widths.
    localparam int NUM_BLOCKS = 64;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // Field widths of one transaction.
    localparam int ACT_W = 2;
    localparam int POS_W = 6;
    localparam int LEN_W = 7;
    localparam int STS_W = 2;

    // Width used for the range checks of the front end.
    localparam int CHK_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 2;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TEST    = 2'd2;

    // Status codes.
    localparam logic [STS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STS_W-1:0] ST_NO_SPACE = 2'd2;
    localparam logic [STS_W-1:0] ST_RANGE    = 2'd3;

    // Request class decided by the front end.
    typedef enum logic [1:0] {
        REQ_ALLOC,
        REQ_RELEASE,
        REQ_TEST,
        REQ_REJECT
    } t_req_kind;

    typedef struct packed {
        t_req_kind         kind;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
    } t_req;

endpackage

`default_nettype wire

FILE: sv/ffba_front.sv
// Front end: accepts transactions, checks their ranges and queues them.
// Depends on ffba_pkg.
`default_nettype none

module ffba_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [ffba_pkg::ACT_W-1:0] i_action,
    input  wire logic [ffba_pkg::POS_W-1:0] i_position,
    input  wire logic [ffba_pkg::LEN_W-1:0] i_run_length,
    output logic                       o_req_valid,
    output ffba_pkg::t_req             o_req,
    input  wire logic                  i_req_ready
);
    import ffba_pkg::*;

    localparam int QDEPTH = 2;

    t_req              r_q [QDEPTH];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    t_req              n_req;
    logic              n_push;
    logic              n_pop;
    logic [CHK_W-1:0]  n_pos_x;
    logic [CHK_W-1:0]  n_len_x;
    logic [CHK_W-1:0]  n_num_x;

    assign n_pos_x = CHK_W'(i_position);
    assign n_len_x = CHK_W'(i_run_length);
    assign n_num_x = CHK_W'(NUM_BLOCKS);

    // Classify the transaction; the full-map test needs live state and is left
    // to the engine.
    always_comb begin
        n_req.pos  = i_position;
        n_req.len  = i_run_length;
        n_req.kind = REQ_REJECT;
        unique case (i_action)
            ACT_ALLOC: begin
                if (n_len_x != '0 && n_len_x <= n_num_x) begin
                    n_req.kind = REQ_ALLOC;
                end
            end
            ACT_RELEASE: begin
                if (n_pos_x != '0 && n_pos_x < n_num_x && n_len_x != '0 &&
                    (n_pos_x + n_len_x) <= n_num_x) begin
                    n_req.kind = REQ_RELEASE;
                end
            end
            ACT_TEST: begin
                if (n_pos_x < n_num_x) begin
                    n_req.kind = REQ_TEST;
                end
            end
            default: n_req.kind = REQ_REJECT;
        endcase
    end

    assign o_ready     = (r_count != 2'(QDEPTH));
    assign o_req_valid = (r_count != 2'd0);
    assign o_req       = r_q[r_rd_ptr];
    assign n_push      = i_valid && o_ready;
    assign n_pop       = o_req_valid && i_req_ready;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wr_ptr] <= n_req;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (n_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + 2'd1;
            end else if (n_pop && !n_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/ffba_engine.sv
// Back end: owns the free map and free count, runs the first-fit scan,
// marks and releases runs and holds the result register. Depends on ffba_pkg.
`default_nettype none

module ffba_engine (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_req_valid,
    input  wire ffba_pkg::t_req        i_req,
    output logic                       o_req_ready,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [ffba_pkg::STS_W-1:0] o_status,
    output logic [ffba_pkg::POS_W-1:0] o_start_block,
    output logic                       o_block_is_free,
    output logic [ffba_pkg::LEN_W-1:0] o_free_blocks
);
    import ffba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_REL,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [NUM_BLOCKS-1:0] r_free_map;
    logic [CNT_W-1:0]     r_free_count;
    logic [BLK_W-1:0]     r_idx;
    logic [BLK_W-1:0]     r_run_start;
    logic [CNT_W-1:0]     r_run_cnt;
    logic [CNT_W-1:0]     r_len;
    logic [CNT_W-1:0]     r_remain;
    logic [STS_W-1:0]     r_res_status;
    logic [BLK_W-1:0]     r_res_start;
    logic                 r_res_free;
    logic                 n_cur_free;
    logic [CNT_W-1:0]     n_run_cnt;
    logic [BLK_W-1:0]     n_run_start;

    assign o_req_ready = (r_state == S_IDLE);
    assign n_cur_free  = r_free_map[r_idx];
    assign n_run_cnt   = r_run_cnt + CNT_W'(1);
    assign n_run_start = (r_run_cnt == '0) ? r_idx : r_run_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_free_map      <= {{(NUM_BLOCKS-1){1'b1}}, 1'b0};
            r_free_count    <= CNT_W'(NUM_BLOCKS - 1);
            o_valid         <= 1'b0;
        end else begin
            // In S_DONE the result register is reloaded below instead.
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_res_start <= '0;
                        r_res_free  <= 1'b0;
                        r_len       <= CNT_W'(i_req.len);
                        r_remain    <= CNT_W'(i_req.len);
                        unique case (i_req.kind)
                            REQ_ALLOC: begin
                                if (r_free_count == '0) begin
                                    r_res_status <= ST_FULL;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_idx     <= '0;
                                    r_run_cnt <= '0;
                                    r_state   <= S_SCAN;
                                end
                            end
                            REQ_RELEASE: begin
                                r_idx   <= BLK_W'(i_req.pos);
                                r_state <= S_REL;
                            end
                            REQ_TEST: begin
                                r_res_free   <= r_free_map[BLK_W'(i_req.pos)];
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                            end
                            default: begin
                                r_res_status <= ST_RANGE;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (n_cur_free && n_run_cnt == r_len) begin
                        r_res_start <= n_run_start;
                        r_idx       <= n_run_start;
                        r_state     <= S_MARK;
                    end else begin
                        if (n_cur_free) begin
                            r_run_cnt   <= n_run_cnt;
                            r_run_start <= n_run_start;
                        end else begin
                            r_run_cnt <= '0;
                        end
                        if (r_idx == BLK_W'(NUM_BLOCKS - 1)) begin
                            r_res_status <= ST_NO_SPACE;
                            r_state      <= S_DONE;
                        end else begin
                            r_idx <= r_idx + BLK_W'(1);
                        end
                    end
                end
                S_MARK: begin
                    r_free_map[r_idx] <= 1'b0;
                    r_free_count      <= r_free_count - CNT_W'(1);
                    r_idx             <= r_idx + BLK_W'(1);
                    r_remain          <= r_remain - CNT_W'(1);
                    if (r_remain == CNT_W'(1)) begin
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                    end
                end
                S_REL: begin
                    if (!n_cur_free) begin
                        r_free_map[r_idx] <= 1'b1;
                        r_free_count      <= r_free_count + CNT_W'(1);
                    end
                    r_idx    <= r_idx + BLK_W'(1);
                    r_remain <= r_remain - CNT_W'(1);
                    if (r_remain == CNT_W'(1)) begin
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid         <= 1'b1;
                        o_status        <= r_res_status;
                        o_start_block   <= POS_W'(r_res_start);
                        o_block_is_free <= r_res_free;
                        o_free_blocks   <= LEN_W'(r_free_count);
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/first_fit_block_allocator_unit.sv
// From the accepting edge to o_valid: a test, a rejected or a memory-full request goes from
// S_IDLE to S_DONE; a release also walks its run in S_REL, block by block; an allocation also
// scans from block 0 until a run fits (the whole map when none fits) and marks the run in S_MARK.
// The engine serves one request at a time; a two-entry queue keeps accepting while it scans
// or while a result waits for i_ready.
// Reset (synchronous, active low): all blocks free except block 0, count NUM_BLOCKS-1.
`default_nettype none

module first_fit_block_allocator_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [ffba_pkg::ACT_W-1:0] i_action,
    input  wire logic [ffba_pkg::POS_W-1:0] i_position,
    input  wire logic [ffba_pkg::LEN_W-1:0] i_run_length,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [ffba_pkg::STS_W-1:0] o_status,
    output logic [ffba_pkg::POS_W-1:0] o_start_block,
    output logic                       o_block_is_free,
    output logic [ffba_pkg::LEN_W-1:0] o_free_blocks
);
    import ffba_pkg::*;

    // The front end classifies each transaction and keeps up to two of them
    // in a queue, so the input side keeps moving while the engine scans or
    // while a finished result waits at the output.
    logic  w_req_valid;
    logic  w_req_ready;
    t_req  w_req;

    ffba_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_run_length (i_run_length),
        .o_req_valid  (w_req_valid),
        .o_req        (w_req),
        .i_req_ready  (w_req_ready)
    );

    // The engine walks the free map one block per cycle. During an allocation
    // it tracks the current run of free blocks; the first run to reach the
    // requested length is the first fit, which it then marks busy block by block.
    ffba_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (w_req_valid),
        .i_req           (w_req),
        .o_req_ready     (w_req_ready),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_start_block   (o_start_block),
        .o_block_is_free (o_block_is_free),
        .o_free_blocks   (o_free_blocks)
    );

    // A failed request never reports a start block or a free block.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_start_block == '0 && !o_block_is_free))
        else $error("failed request carries a start block or free flag");

    // Block 0 stays reserved, so the count never reaches the full map.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_free_blocks <= LEN_W'(NUM_BLOCKS - 1)))
        else $error("free count exceeds the usable blocks");

    // Memory full is reported only when no block is free.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_free_blocks == '0))
        else $error("memory full reported with free blocks left");

    // A successful result with a zero start block never carries an unknown status.
    a_no_block0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK && o_start_block == '0) |-> !$isunknown(o_status))
        else $error("unknown status with a zero start block");

    // Reset clears the result valid flag.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
